// ----- hdl/load_adaptive_level_governor_macros.svh -----
// Assertion macros shared by the checker of the level governor.
// The macros expect signals named clk and rst_n in the scope where they are used.
`ifndef LOAD_ADAPTIVE_LEVEL_GOVERNOR_MACROS_SVH
`define LOAD_ADAPTIVE_LEVEL_GOVERNOR_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define LALG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lalg: same-cycle check failed");

// Next-cycle implication, checked only while out of reset.
`define LALG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lalg: next-cycle check failed");

// Delayed implication, checked only while out of reset.
`define LALG_ASSERT_DLY2(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error("lalg: two-cycle check failed");

`endif

// ----- hdl/lalg_pkg.sv -----
// Package for the load-adaptive level governor: widths, word layouts,
// register indexes, reset values and the CPU decision struct. No dependencies.
`timescale 1ns / 1ps

package lalg_pkg;

  localparam int LEVEL_BITS       = 10;
  localparam int COUNTER_BITS_DEF = 64;

  // Fixed field widths.
  localparam int LVL_W   = LEVEL_BITS;
  localparam int PCT_W   = 7;
  localparam int QUEUE_W = 16;
  localparam int CNT_W   = 63;

  // Input word layout, lowest bit first.
  localparam int QS_LSB     = 0;
  localparam int UTIL_LSB   = QS_LSB + QUEUE_W;
  localparam int ADV_BIT    = UTIL_LSB + PCT_W;
  localparam int UPQ_LSB    = ADV_BIT + 1;
  localparam int OK_BIT     = UPQ_LSB + QUEUE_W;
  localparam int TOT_LSB    = OK_BIT + 1;
  localparam int IDL_LSB    = TOT_LSB + CNT_W;
  localparam int APPLY_BIT  = IDL_LSB + CNT_W;
  localparam int IN_USED    = APPLY_BIT + 1;
  localparam int IN_W       = ((IN_USED + 7) / 8) * 8;

  // Output word layout, lowest bit first.
  localparam int OUT_USED = LVL_W + 4;
  localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ENABLE       = 3'd0,
    REG_MAX_LEVEL    = 3'd1,
    REG_MIN_LEVEL    = 3'd2,
    REG_QUEUE_THR    = 3'd3,
    REG_IO_BUSY_PCT  = 3'd4,
    REG_CPU_BUSY_PCT = 3'd5,
    REG_CLOUD_MODE   = 3'd6,
    REG_CLOUD_THR    = 3'd7
  } cfg_reg_t;

  // Register reset values.
  localparam logic               ENABLE_RST    = 1'b1;
  localparam logic [LVL_W-1:0]   MAX_LEVEL_RST = 10'd16;
  localparam logic [LVL_W-1:0]   MIN_LEVEL_RST = 10'd2;
  localparam logic [QUEUE_W-1:0] QUEUE_THR_RST = 16'd10;
  localparam logic [PCT_W-1:0]   IO_PCT_RST    = 7'd90;
  localparam logic [PCT_W-1:0]   CPU_PCT_RST   = 7'd90;
  localparam logic               CLOUD_RST     = 1'b0;
  localparam logic [QUEUE_W-1:0] CLOUD_THR_RST = 16'd100;

  localparam logic [PCT_W-1:0] PERCENT_SCALE = 7'd100;
  localparam int STEP_UP   = 1;
  localparam int STEP_DOWN = 2;

  // CPU decision handed from the checker unit to the top level.
  typedef struct packed {
    logic busy;     // decision for this tick, also the next held flag
    logic base_we;  // take this sample as the new baseline
  } cpu_dec_t;

endpackage

// ----- hdl/load_adaptive_level_governor.sv -----
// Load-adaptive level governor: one tick word in, one result word out.
// Channels: in_* carries a tick (queue depths, IO utilization, CPU counters,
// apply flag); out_* returns the committed level and this tick's decisions.
// cfg_* writes one of eight registers in a cycle with cfg_wr_en high; write
// only while no tick is in flight.
// A word accepted into the input register moves on to the result register
// when that register is empty or its word is taken, and is offered from there.
// Throughput: one word per cycle while the receiver keeps up. All work of a
// tick is one pass from the input register to the result register, and the
// level and CPU baseline it leaves are ready for the very next tick.
// Reset (rst_n low, synchronous) loads the register defaults, sets the level
// to 16 and clears the CPU baseline and held busy flags; no word is valid.
// When out_tready is low the result word holds, one more tick waits in the
// input register, and in_tready drops until the result is taken.
// Depends on lalg_pkg and lalg_cpu_check.
`timescale 1ns / 1ps

module load_adaptive_level_governor #(
  parameter int COUNTER_BITS = lalg_pkg::COUNTER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // queue depth, io_util_percent, io_time_advanced, upload_queue_size,
  // cpu_sample_ok, cpu_total, cpu_idle, apply_ok
  input  logic [lalg_pkg::IN_W-1:0]       in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // level, changed, queue_high, io_busy, cpu busy flag
  output logic [lalg_pkg::OUT_W-1:0]      out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [lalg_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [lalg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lalg_pkg::*;

  localparam int TW = LVL_W + 2;
  localparam logic signed [TW-1:0] UP_S   = TW'(STEP_UP);
  localparam logic signed [TW-1:0] DOWN_S = TW'(STEP_DOWN);

  // Configuration registers.
  logic               enable_r;
  logic [LVL_W-1:0]   max_level_r;
  logic [LVL_W-1:0]   min_level_r;
  logic [QUEUE_W-1:0] queue_thr_r;
  logic [PCT_W-1:0]   io_pct_r;
  logic [PCT_W-1:0]   cpu_pct_r;
  logic               cloud_mode_r;
  logic [QUEUE_W-1:0] cloud_thr_r;

  // Governor state.
  logic [LVL_W-1:0]        level_r, level_nxt;
  logic [COUNTER_BITS-1:0] base_total_r;
  logic [COUNTER_BITS-1:0] base_idle_r;
  logic                    base_valid_r;
  logic                    cpu_held_r;
  logic                    io_held_r, io_held_nxt;

  // Input and result registers.
  logic                    in_valid_r;
  logic [IN_W-1:0]         in_data_r;
  logic                    out_valid_r;
  logic [OUT_W-1:0]        out_data_r, out_data_nxt;
  logic                    fire;

  // Fields of the registered tick.
  logic [QUEUE_W-1:0]      f_queue;
  logic [PCT_W-1:0]        f_util;
  logic                    f_adv;
  logic [QUEUE_W-1:0]      f_upq;
  logic                    f_ok;
  logic [COUNTER_BITS-1:0] f_total;
  logic [COUNTER_BITS-1:0] f_idle;
  logic                    f_apply;

  logic                    queue_high;
  logic                    io_busy;
  logic                    commit;
  cpu_dec_t                cpu_dec;
  logic signed [TW-1:0]    lo, hi, t0, t1, t2, t3, t4;

  assign f_queue = in_data_r[QS_LSB +: QUEUE_W];
  assign f_util  = in_data_r[UTIL_LSB +: PCT_W];
  assign f_adv   = in_data_r[ADV_BIT];
  assign f_upq   = in_data_r[UPQ_LSB +: QUEUE_W];
  assign f_ok    = in_data_r[OK_BIT];
  assign f_total = COUNTER_BITS'(in_data_r[TOT_LSB +: CNT_W]);
  assign f_idle  = COUNTER_BITS'(in_data_r[IDL_LSB +: CNT_W]);
  assign f_apply = in_data_r[APPLY_BIT];

  assign fire       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || fire;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  lalg_cpu_check #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_cpu (
    .sample_ok      (f_ok),
    .cur_total      (f_total),
    .cur_idle       (f_idle),
    .base_total     (base_total_r),
    .base_idle      (base_idle_r),
    .baseline_valid (base_valid_r),
    .busy_held      (cpu_held_r),
    .busy_pct       (cpu_pct_r),
    .dec            (cpu_dec)
  );

  // IO decision: cloud mode tests the upload queue and leaves the held flag.
  always_comb begin
    io_held_nxt = io_held_r;
    if (cloud_mode_r) begin
      io_busy = f_upq > cloud_thr_r;
    end else if (f_adv) begin
      io_busy     = f_util > io_pct_r;
      io_held_nxt = io_busy;
    end else begin
      io_busy = io_held_r;
    end
  end

  // Level steps in signed arithmetic; a zero minimum acts as one.
  always_comb begin
    lo = (min_level_r == '0) ? TW'(1) : TW'(min_level_r);
    hi = TW'(max_level_r);
    t0 = TW'(level_r);
    queue_high = f_queue > queue_thr_r;
    t1 = t0;
    if (queue_high) begin
      t1 = (t0 + UP_S < hi) ? t0 + UP_S : hi;
    end
    t2 = t1;
    if (io_busy) begin
      t2 = (t1 - DOWN_S > lo) ? t1 - DOWN_S : lo;
    end
    t3 = t2;
    if (cpu_dec.busy) begin
      t3 = (t2 - DOWN_S > lo) ? t2 - DOWN_S : lo;
    end
    // Clamp to the upper bound first so a reversed pair ends at the minimum.
    t4 = (t3 > hi) ? hi : t3;
    if (t4 < lo) begin
      t4 = lo;
    end
    commit    = (t4 != t0) && f_apply;
    level_nxt = commit ? LVL_W'(t4) : level_r;
  end

  always_comb begin
    out_data_nxt = '0;
    if (enable_r) begin
      out_data_nxt[LVL_W-1:0] = level_nxt;
      out_data_nxt[LVL_W]     = commit;
      out_data_nxt[LVL_W + 1] = queue_high;
      out_data_nxt[LVL_W + 2] = io_busy;
      out_data_nxt[LVL_W + 3] = cpu_dec.busy;
    end else begin
      out_data_nxt[LVL_W-1:0] = level_r;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= ENABLE_RST;
      max_level_r  <= MAX_LEVEL_RST;
      min_level_r  <= MIN_LEVEL_RST;
      queue_thr_r  <= QUEUE_THR_RST;
      io_pct_r     <= IO_PCT_RST;
      cpu_pct_r    <= CPU_PCT_RST;
      cloud_mode_r <= CLOUD_RST;
      cloud_thr_r  <= CLOUD_THR_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_ENABLE:       enable_r     <= cfg_wdata[0];
        REG_MAX_LEVEL:    max_level_r  <= cfg_wdata[LVL_W-1:0];
        REG_MIN_LEVEL:    min_level_r  <= cfg_wdata[LVL_W-1:0];
        REG_QUEUE_THR:    queue_thr_r  <= cfg_wdata[QUEUE_W-1:0];
        REG_IO_BUSY_PCT:  io_pct_r     <= cfg_wdata[PCT_W-1:0];
        REG_CPU_BUSY_PCT: cpu_pct_r    <= cfg_wdata[PCT_W-1:0];
        REG_CLOUD_MODE:   cloud_mode_r <= cfg_wdata[0];
        REG_CLOUD_THR:    cloud_thr_r  <= cfg_wdata[QUEUE_W-1:0];
        default: ;
      endcase
    end
  end

  // Governor state, updated as each tick leaves the input register while enabled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r      <= MAX_LEVEL_RST;
      base_total_r <= '0;
      base_idle_r  <= '0;
      base_valid_r <= 1'b0;
      cpu_held_r   <= 1'b0;
      io_held_r    <= 1'b0;
    end else if (fire && enable_r) begin
      level_r    <= level_nxt;
      cpu_held_r <= cpu_dec.busy;
      io_held_r  <= io_held_nxt;
      if (cpu_dec.base_we) begin
        base_total_r <= f_total;
        base_idle_r  <= f_idle;
        base_valid_r <= 1'b1;
      end
    end
  end

  // Handshake control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
    end
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ----- hdl/lalg_cpu_check.sv -----
// CPU busy decision of the level governor: counter deltas against the stored
// baseline, checked for sanity and compared by cross-multiplication. Uses lalg_pkg.
`timescale 1ns / 1ps

module lalg_cpu_check #(
  parameter int COUNTER_BITS = lalg_pkg::COUNTER_BITS_DEF
) (
  input  logic                       sample_ok,
  input  logic [COUNTER_BITS-1:0]    cur_total,
  input  logic [COUNTER_BITS-1:0]    cur_idle,
  input  logic [COUNTER_BITS-1:0]    base_total,
  input  logic [COUNTER_BITS-1:0]    base_idle,
  input  logic                       baseline_valid,
  input  logic                       busy_held,
  input  logic [lalg_pkg::PCT_W-1:0] busy_pct,
  output lalg_pkg::cpu_dec_t         dec
);
  import lalg_pkg::*;

  localparam int PW = COUNTER_BITS + PCT_W;

  logic [COUNTER_BITS-1:0] d_total;
  logic [COUNTER_BITS-1:0] d_idle;
  logic                    bad_sample;
  logic [PW-1:0]           busy_scaled;
  logic [PW-1:0]           thr_scaled;

  assign d_total = cur_total - base_total;
  assign d_idle  = cur_idle - base_idle;

  // A sample is rejected when total did not advance or idle went backward
  // or grew faster than total.
  assign bad_sample = (cur_total <= base_total) || (cur_idle < base_idle) ||
                      (d_idle > d_total);

  // Busy delta * 100 against busy_pct * total delta, exact in PW bits.
  assign busy_scaled = PW'(d_total - d_idle) * PW'(PERCENT_SCALE);
  assign thr_scaled  = PW'(d_total) * PW'(busy_pct);

  always_comb begin
    if (!sample_ok) begin
      dec.busy    = busy_held;
      dec.base_we = 1'b0;
    end else if (!baseline_valid) begin
      dec.busy    = 1'b0;
      dec.base_we = 1'b1;
    end else if (bad_sample) begin
      dec.busy    = busy_held;
      dec.base_we = 1'b0;
    end else begin
      dec.busy    = busy_scaled > thr_scaled;
      dec.base_we = 1'b1;
    end
  end

endmodule

// ----- hdl/lalg_checker.sv -----
// Port-level checker for the level governor and the bind that attaches it.
// Depends on lalg_pkg and load_adaptive_level_governor_macros.svh.
`timescale 1ns / 1ps
`include "load_adaptive_level_governor_macros.svh"

module lalg_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [lalg_pkg::OUT_W-1:0] out_tdata
);
  import lalg_pkg::*;

  // No result word may appear in the cycle right after reset is released.
  `LALG_ASSERT_IMP(a_reset_clear, $rose(rst_n), !out_tvalid)

  // A stalled result word holds.
  `LALG_ASSERT_NXT(a_stall_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // Every accepted tick is followed by a valid word on the output port.
  `LALG_ASSERT_DLY2(a_latency, in_tvalid && in_tready, out_tvalid)

  // A receiver that keeps up never holds back the input side.
  `LALG_ASSERT_IMP(a_no_bubble, out_tready, in_tready)

endmodule

bind load_adaptive_level_governor lalg_checker u_lalg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- test/load_adaptive_level_governor_checker.sv -----
// Checker for the level governor: predicts the result word of every accepted tick
// and compares it with the block's output. Depends on lalg_pkg.
`timescale 1ns / 1ps

module load_adaptive_level_governor_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // queue depth, io_util_percent, io_time_advanced, upload_queue_size,
  // cpu_sample_ok, cpu_total, cpu_idle, apply_ok
  input  logic [lalg_pkg::IN_W-1:0]       in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // level, changed, queue_high, io_busy, cpu busy flag
  input  logic [lalg_pkg::OUT_W-1:0]      out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [lalg_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [lalg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              pending
);
  import lalg_pkg::*;

  // Packed so that the last field sits in the lowest bits.
  typedef struct packed {
    logic               apply;
    logic [CNT_W-1:0]   idle;
    logic [CNT_W-1:0]   total;
    logic               sample_ok;
    logic [QUEUE_W-1:0] upload;
    logic               advanced;
    logic [PCT_W-1:0]   util;
    logic [QUEUE_W-1:0] queue;
  } tick_t;

  typedef struct packed {
    logic [OUT_W-OUT_USED-1:0] pad;
    logic                      cpu_hot;
    logic                      io_busy;
    logic                      queue_high;
    logic                      changed;
    logic [LVL_W-1:0]          level;
  } result_t;

  // Register copies.
  logic               gov_en;
  logic [LVL_W-1:0]   max_lvl, min_lvl;
  logic [QUEUE_W-1:0] queue_thr, cloud_thr;
  logic [PCT_W-1:0]   io_pct, cpu_pct;
  logic               cloud_on;

  // Governor state.
  logic [LVL_W-1:0] cur_level;
  logic [63:0]      base_tot, base_idl;
  logic             base_valid, cpu_held, io_held;

  result_t pending_results[$];
  int      fails;

  function automatic result_t govern_tick(input tick_t t);
    result_t     r;
    int          lo, hi, lvl;
    logic        qh, iob, cpb;
    logic [63:0] tot, idl, dt, di;
    logic [71:0] busy_scaled, limit_scaled;
    r = '0;
    if (!gov_en) begin
      r.level = cur_level;
      return r;
    end
    lo  = (min_lvl == 0) ? 1 : int'(min_lvl);
    hi  = int'(max_lvl);
    lvl = int'(cur_level);

    qh = t.queue > queue_thr;
    if (qh) lvl = (lvl + STEP_UP < hi) ? lvl + STEP_UP : hi;

    if (cloud_on) begin
      iob = t.upload > cloud_thr;
    end else if (!t.advanced) begin
      iob = io_held;
    end else begin
      io_held = t.util > io_pct;
      iob = io_held;
    end
    if (iob) lvl = (lvl - STEP_DOWN > lo) ? lvl - STEP_DOWN : lo;

    tot = {1'b0, t.total};
    idl = {1'b0, t.idle};
    cpb = cpu_held;
    if (t.sample_ok) begin
      if (!base_valid) begin
        base_tot   = tot;
        base_idl   = idl;
        base_valid = 1'b1;
        cpu_held   = 1'b0;
        cpb        = 1'b0;
      end else if (tot > base_tot && idl >= base_idl &&
                   (idl - base_idl) <= (tot - base_tot)) begin
        dt = tot - base_tot;
        di = idl - base_idl;
        base_tot = tot;
        base_idl = idl;
        busy_scaled  = 72'(dt - di);
        busy_scaled  = busy_scaled * 100;
        limit_scaled = 72'(dt);
        limit_scaled = limit_scaled * cpu_pct;
        cpu_held = busy_scaled > limit_scaled;
        cpb = cpu_held;
      end
    end
    if (cpb) lvl = (lvl - STEP_DOWN > lo) ? lvl - STEP_DOWN : lo;

    if (lvl > hi) lvl = hi;
    if (lvl < lo) lvl = lo;
    if (lvl != int'(cur_level) && t.apply) begin
      cur_level = lvl[LVL_W-1:0];
      r.changed = 1'b1;
    end
    r.level      = cur_level;
    r.queue_high = qh;
    r.io_busy    = iob;
    r.cpu_hot    = cpb;
    return r;
  endfunction

  function automatic void report(input string msg);
    fails++;
    if (fails <= 10) $display("%t: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin
    result_t got, want;
    if (!rst_n) begin
      gov_en     = ENABLE_RST;
      max_lvl    = MAX_LEVEL_RST;
      min_lvl    = MIN_LEVEL_RST;
      queue_thr  = QUEUE_THR_RST;
      io_pct     = IO_PCT_RST;
      cpu_pct    = CPU_PCT_RST;
      cloud_on   = CLOUD_RST;
      cloud_thr  = CLOUD_THR_RST;
      cur_level  = MAX_LEVEL_RST;
      base_tot   = '0;
      base_idl   = '0;
      base_valid = 1'b0;
      cpu_held   = 1'b0;
      io_held    = 1'b0;
      pending_results.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_addr))
          REG_ENABLE:       gov_en    = cfg_wdata[0];
          REG_MAX_LEVEL:    max_lvl   = cfg_wdata[LVL_W-1:0];
          REG_MIN_LEVEL:    min_lvl   = cfg_wdata[LVL_W-1:0];
          REG_QUEUE_THR:    queue_thr = cfg_wdata[QUEUE_W-1:0];
          REG_IO_BUSY_PCT:  io_pct    = cfg_wdata[PCT_W-1:0];
          REG_CPU_BUSY_PCT: cpu_pct   = cfg_wdata[PCT_W-1:0];
          REG_CLOUD_MODE:   cloud_on  = cfg_wdata[0];
          REG_CLOUD_THR:    cloud_thr = cfg_wdata[QUEUE_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        pending_results.insert(pending_results.size(), govern_tick(tick_t'(in_tdata)));
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata);
        if (pending_results.size() == 0) begin
          report($sformatf({"result word with nothing expected:",
                            " level=%0d changed=%b qh=%b io=%b cpu=%b"},
                           got.level, got.changed, got.queue_high, got.io_busy,
                           got.cpu_hot));
        end else begin
          want = pending_results.pop_front();
          if (got.level !== want.level || got.changed !== want.changed ||
              got.queue_high !== want.queue_high || got.io_busy !== want.io_busy ||
              got.cpu_hot !== want.cpu_hot)
            report($sformatf({"mismatch: expected level=%0d changed=%b qh=%b io=%b cpu=%b,",
                              " got level=%0d changed=%b qh=%b io=%b cpu=%b"},
                             want.level, want.changed, want.queue_high, want.io_busy,
                             want.cpu_hot, got.level, got.changed, got.queue_high,
                             got.io_busy, got.cpu_hot));
        end
      end
    end
    fail_count <= fails;
    pending    <= pending_results.size();
  end

endmodule

// ----- test/load_adaptive_level_governor_tb.sv -----
// Top of the level governor testbench: clock, reset, tick and register stimulus,
// verdict. Depends on lalg_pkg, the governor and load_adaptive_level_governor_checker.
`timescale 1ns / 1ps

module load_adaptive_level_governor_tb;
  import lalg_pkg::*;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  int                    fail_count;
  int                    pending;

  int             send_idle = 36;
  int             recv_idle = 45;
  bit             hold_out  = 1'b0;
  logic [15:0]    cfg_val[8];
  logic [CNT_W-1:0] tot_run, idl_run;

  load_adaptive_level_governor u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  load_adaptive_level_governor_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("load_adaptive_level_governor regression: fail");
    $finish;
  end

  // Receiver: random stalls, or one long hold-off when asked for.
  initial begin
    forever begin
      if (hold_out) begin
        out_tready <= 1'b0;
        repeat (80) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) < recv_idle) ? 1'b0 : 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_tick(input logic [15:0] qs, input logic [6:0] util, input logic adv,
                           input logic [15:0] upq, input logic ok, input logic [62:0] tot,
                           input logic [62:0] idl, input logic apply);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {apply, idl, tot, ok, upq, adv, util, qs};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Waits until every result has come back, then lets the pipeline settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic load_config();
    for (int i = 0; i < 8; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_addr  <= cfg_reg_t'(i);
      cfg_wdata <= cfg_val[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  function automatic int near_value(input int center, input int maxv);
    int v;
    v = center + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    if (v > maxv) v = maxv;
    return v;
  endfunction

  function automatic void random_config();
    cfg_val[REG_ENABLE]       = 16'($urandom_range(7) != 0);
    cfg_val[REG_MAX_LEVEL]    = 16'($urandom_range(1) ? $urandom_range(1, 40)
                                                      : $urandom_range(1, 1023));
    cfg_val[REG_MIN_LEVEL]    = 16'($urandom_range(3) ? $urandom_range(1, 30)
                                                      : $urandom_range(1, 1023));
    cfg_val[REG_QUEUE_THR]    = 16'($urandom_range(1) ? $urandom_range(0, 40) : $urandom);
    cfg_val[REG_IO_BUSY_PCT]  = 16'($urandom_range(0, 100));
    cfg_val[REG_CPU_BUSY_PCT] = 16'($urandom_range(0, 100));
    cfg_val[REG_CLOUD_MODE]   = 16'($urandom_range(1));
    cfg_val[REG_CLOUD_THR]    = 16'($urandom_range(1) ? $urandom_range(0, 40) : $urandom);
  endfunction

  // Mostly well-formed counter sequences so the CPU decision sees real deltas;
  // the rest are failed, invalid or arbitrary samples.
  task automatic send_random();
    logic [15:0]      qs, upq;
    logic [6:0]       util;
    logic [CNT_W-1:0] tot, idl;
    logic [63:0]      dt, di;
    int               pick, k, pct;
    pick = $urandom_range(2);
    qs  = (pick == 0) ? 16'($urandom) :
          (pick == 1) ? 16'(near_value(int'(cfg_val[REG_QUEUE_THR]), 65535))
                      : 16'($urandom_range(0, 30));
    pick = $urandom_range(2);
    upq = (pick == 0) ? 16'($urandom) :
          (pick == 1) ? 16'(near_value(int'(cfg_val[REG_CLOUD_THR]), 65535))
                      : 16'($urandom_range(0, 30));
    util = $urandom_range(1) ? 7'(near_value(int'(cfg_val[REG_IO_BUSY_PCT]), 100))
                             : 7'($urandom_range(0, 100));
    pick = $urandom_range(99);
    if (pick < 75) begin
      case ($urandom_range(3))
        0:       dt = 64'($urandom_range(1, 100));
        1:       dt = 64'($urandom_range(1, 1000000));
        2:       dt = {32'd0, $urandom} + 64'd1;
        default: dt = ({32'd0, $urandom} << $urandom_range(0, 20)) + 64'd1;
      endcase
      di = dt * $urandom_range(0, 100) / 100;
      tot_run += dt[CNT_W-1:0];
      idl_run += di[CNT_W-1:0];
      tot = tot_run;
      idl = idl_run;
    end else if (pick < 85) begin
      // Busy share lands exactly on the threshold, which must not count as busy.
      k   = $urandom_range(1, 1000);
      pct = int'(cfg_val[REG_CPU_BUSY_PCT]);
      tot_run += CNT_W'(100 * k);
      idl_run += CNT_W'(k * (100 - pct));
      tot = tot_run;
      idl = idl_run;
    end else if (pick < 93) begin
      case ($urandom_range(2))
        0: begin
          tot = tot_run;
          idl = idl_run;
        end
        1: begin
          tot = tot_run + 63'd5;
          idl = idl_run - 63'd1;
        end
        default: begin
          tot = tot_run + 63'd5;
          idl = idl_run + 63'd6;
        end
      endcase
    end else begin
      tot = CNT_W'({$urandom, $urandom});
      idl = CNT_W'({$urandom, $urandom});
      if ($urandom_range(1)) begin
        tot = tot >> 1;
        idl = tot >> $urandom_range(1, 8);
        tot_run = tot;
        idl_run = idl;
      end
    end
    send_tick(qs, util, $urandom_range(99) < 60, upq, $urandom_range(99) < 88,
              tot, idl, $urandom_range(99) < 85);
  endtask

  initial begin
    cfg_val[REG_ENABLE]       = 16'(ENABLE_RST);
    cfg_val[REG_MAX_LEVEL]    = 16'(MAX_LEVEL_RST);
    cfg_val[REG_MIN_LEVEL]    = 16'(MIN_LEVEL_RST);
    cfg_val[REG_QUEUE_THR]    = QUEUE_THR_RST;
    cfg_val[REG_IO_BUSY_PCT]  = 16'(IO_PCT_RST);
    cfg_val[REG_CPU_BUSY_PCT] = 16'(CPU_PCT_RST);
    cfg_val[REG_CLOUD_MODE]   = 16'(CLOUD_RST);
    cfg_val[REG_CLOUD_THR]    = CLOUD_THR_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed ticks with the reset settings: first CPU sample, a busy sample,
    // failed, non-increasing, idle-decreasing and idle-exceeding samples, the
    // exact threshold, a refused apply and the field extremes.
    send_tick(16'd0, 7'd0, 1'b0, 16'd0, 1'b1, 63'd1000, 63'd500, 1'b1);
    send_tick(16'hffff, 7'd50, 1'b1, 16'hffff, 1'b1, 63'd2000, 63'd510, 1'b1);
    send_tick(16'd0, 7'd100, 1'b1, 16'd0, 1'b0, 63'd0, 63'd0, 1'b0);
    send_tick(16'd0, 7'd0, 1'b0, 16'd0, 1'b1, 63'd2000, 63'd600, 1'b1);
    send_tick(16'd0, 7'd0, 1'b0, 16'd0, 1'b1, 63'd2500, 63'd400, 1'b1);
    send_tick(16'd0, 7'd0, 1'b0, 16'd0, 1'b1, 63'd3000, 63'd2000, 1'b1);
    send_tick(16'd11, 7'd0, 1'b1, 16'd0, 1'b1, 63'd4000, 63'd1500, 1'b1);
    send_tick(16'd0, 7'd0, 1'b0, 16'd0, 1'b1, 63'd4100, 63'd1510, 1'b1);
    send_tick(16'd0, 7'd0, 1'b0, 16'd0, 1'b1, 63'h4000_0000_0000_0000, 63'd1510, 1'b1);
    send_tick(16'd0, 7'd0, 1'b0, 16'd0, 1'b0, '1, '1, 1'b1);
    send_tick(16'd10, 7'd90, 1'b1, 16'd0, 1'b1, 63'h4000_0000_0000_0000, 63'd1510, 1'b1);
    tot_run = 63'h4000_0000_0000_0000;
    idl_run = 63'd1510;

    // Lowered max under the current level, zero minimum, cloud mode.
    drain();
    cfg_val[REG_MAX_LEVEL]  = 16'd5;
    cfg_val[REG_MIN_LEVEL]  = 16'd0;
    cfg_val[REG_CLOUD_MODE] = 16'd1;
    cfg_val[REG_CLOUD_THR]  = 16'd0;
    load_config();
    send_tick(16'hffff, 7'd0, 1'b0, 16'd0, 1'b0, 63'd0, 63'd0, 1'b1);
    send_tick(16'd0, 7'd0, 1'b0, 16'd1, 1'b0, 63'd0, 63'd0, 1'b1);
    send_tick(16'd0, 7'd100, 1'b1, 16'hffff, 1'b0, 63'd0, 63'd0, 1'b1);

    // Minimum above maximum.
    drain();
    cfg_val[REG_MIN_LEVEL]  = 16'd20;
    cfg_val[REG_CLOUD_MODE] = 16'd0;
    cfg_val[REG_CLOUD_THR]  = 16'hffff;
    load_config();
    send_tick(16'd0, 7'd0, 1'b0, 16'd0, 1'b0, 63'd0, 63'd0, 1'b1);
    send_tick(16'hffff, 7'd100, 1'b1, 16'hffff, 1'b0, 63'd0, 63'd0, 1'b0);

    // Disabled governor.
    drain();
    cfg_val[REG_ENABLE] = 16'd0;
    load_config();
    send_tick(16'hffff, 7'd100, 1'b1, 16'hffff, 1'b1, '1, '1, 1'b1);
    send_tick(16'd0, 7'd0, 1'b1, 16'd0, 1'b1, 63'd0, 63'd0, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      if (ph < 2) begin
        send_idle = 36;
        recv_idle = 45;
      end else if (ph < 4) begin
        send_idle = 45;
        recv_idle = 36;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (ph == 1) begin
        cfg_val[REG_ENABLE]       = 16'd1;
        cfg_val[REG_MAX_LEVEL]    = 16'd1023;
        cfg_val[REG_MIN_LEVEL]    = 16'd1;
        cfg_val[REG_QUEUE_THR]    = 16'd0;
        cfg_val[REG_IO_BUSY_PCT]  = 16'd0;
        cfg_val[REG_CPU_BUSY_PCT] = 16'd0;
        cfg_val[REG_CLOUD_MODE]   = 16'd0;
        cfg_val[REG_CLOUD_THR]    = 16'd0;
      end else if (ph == 3) begin
        cfg_val[REG_ENABLE]       = 16'd1;
        cfg_val[REG_MAX_LEVEL]    = 16'd1;
        cfg_val[REG_MIN_LEVEL]    = 16'd1023;
        cfg_val[REG_QUEUE_THR]    = 16'hffff;
        cfg_val[REG_IO_BUSY_PCT]  = 16'd100;
        cfg_val[REG_CPU_BUSY_PCT] = 16'd100;
        cfg_val[REG_CLOUD_MODE]   = 16'd1;
        cfg_val[REG_CLOUD_THR]    = 16'hffff;
      end else begin
        random_config();
        cfg_val[REG_ENABLE] = (ph == 0) ? 16'd1 : cfg_val[REG_ENABLE];
      end
      load_config();
      // With nothing idling, a long receiver hold-off backs the block up.
      if (ph == 4) hold_out = 1'b1;
      repeat (92) send_random();
    end

    drain();
    if (fail_count == 0 && pending == 0)
      $display("load_adaptive_level_governor regression: pass");
    else
      $display("load_adaptive_level_governor regression: fail");
    $finish;
  end

endmodule
